[hdl/strided_tensor_bounds_check_macros.svh]
// Assertion macros shared by the strided tensor bounds checker.
`ifndef STRIDED_TENSOR_BOUNDS_CHECK_MACROS_SVH
`define STRIDED_TENSOR_BOUNDS_CHECK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STBC_ASSERT_NOW(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STBC_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/stbc_pkg.sv]
// Shared types and status codes of the strided tensor bounds checker.
package stbc_pkg;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NEG_EXT = 3'd1;
  localparam logic [2:0] ST_NEG_OFF = 3'd2;
  localparam logic [2:0] ST_CNT     = 3'd3;
  localparam logic [2:0] ST_BND     = 3'd4;

  typedef struct packed {
    logic [63:0] ext;
    logic [63:0] str;
    logic [63:0] base;
    logic        scalar;
    logic        last;
    logic        first;
  } item_t;

  typedef struct packed {
    logic [63:0] ext;
    logic [63:0] base;
    logic [63:0] p;
    logic        scalar;
    logic        last;
    logic        first;
    logic        neg;
    logic        pnz;
    logic        bnd_mul;
  } dim_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
  } pipe_ctl_t;

  typedef struct packed {
    logic neg_ext;
    logic neg_off;
    logic zero;
    logic cnt;
    logic bnd;
  } flags_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        empty;
    logic [63:0] lowest;
    logic [63:0] highest;
  } result_t;

endpackage

[hdl/stbc_span.sv]
// Two-stage span product (extent - 1) * |stride| with overflow against the offset range.
module stbc_span (
  input  logic               clk,
  input  stbc_pkg::pipe_ctl_t ctl,
  input  stbc_pkg::item_t    item,
  output stbc_pkg::dim_t     dim
);
  import stbc_pkg::*;

  typedef struct packed {
    logic [63:0] ext;
    logic [63:0] base;
    logic [63:0] pp0;
    logic [63:0] pp1;
    logic        scalar;
    logic        last;
    logic        first;
    logic        neg;
    logic        big;
  } prod_t;

  prod_t       stage_a;
  prod_t       stage_a_next;
  dim_t        dim_next;
  logic [63:0] a;
  logic [63:0] mag;
  logic        a_big;
  logic        m_big;
  logic [31:0] s;
  logic [63:0] l;
  logic [95:0] full;
  logic        over_pos;
  logic        over_neg;

  // Where the product stays in range, one factor fits in 32 bits.
  always_comb begin
    a     = item.ext - 64'd1;
    mag   = item.str[63] ? (64'd0 - item.str) : item.str;
    a_big = (a[63:32] != 32'd0);
    m_big = (mag[63:32] != 32'd0);
    s     = a_big ? mag[31:0] : a[31:0];
    l     = a_big ? a : mag;
    stage_a_next.ext    = item.ext;
    stage_a_next.base   = item.base;
    stage_a_next.pp0    = 64'(s) * 64'(l[31:0]);
    stage_a_next.pp1    = 64'(s) * 64'(l[63:32]);
    stage_a_next.scalar = item.scalar;
    stage_a_next.last   = item.last;
    stage_a_next.first  = item.first;
    stage_a_next.neg    = item.str[63];
    stage_a_next.big    = a_big && m_big;
  end

  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      stage_a <= stage_a_next;
    end
  end

  always_comb begin
    full     = {stage_a.pp1, 32'd0} + {32'd0, stage_a.pp0};
    over_pos = (full[95:63] != 33'd0);
    over_neg = (full[95:64] != 32'd0) || (full[63] && (full[62:0] != 63'd0));
    dim_next.ext     = stage_a.ext;
    dim_next.base    = stage_a.base;
    dim_next.p       = full[63:0];
    dim_next.scalar  = stage_a.scalar;
    dim_next.last    = stage_a.last;
    dim_next.first   = stage_a.first;
    dim_next.neg     = stage_a.neg;
    dim_next.pnz     = (full[63:0] != 64'd0);
    dim_next.bnd_mul = stage_a.big || (stage_a.neg ? over_neg : over_pos);
  end

  always_ff @(posedge clk) begin
    if (ctl.load_b) begin
      dim <= dim_next;
    end
  end

endmodule

[hdl/stbc_accum.sv]
// Running offset range, element count and sticky error flags, with the closing result.
module stbc_accum (
  input  logic              clk,
  input  logic              take,
  input  stbc_pkg::dim_t    dim,
  output stbc_pkg::result_t res
);
  import stbc_pkg::*;

  logic [63:0] run_low;
  logic [63:0] run_high;
  logic [63:0] start_offset;
  logic [63:0] elem_count;
  flags_t      error_flags;

  logic [63:0] run_low_next;
  logic [63:0] run_high_next;
  logic [63:0] start_offset_next;
  logic [63:0] elem_count_next;
  flags_t      error_flags_next;

  logic [63:0] low0;
  logic [63:0] high0;
  logic [63:0] cnt0;
  flags_t      fl0;
  logic        c_big;
  logic        e_big;
  logic [31:0] s;
  logic [63:0] l;
  logic [63:0] q0;
  logic [63:0] q1;
  logic [95:0] prod;
  logic        cnt_ovf;
  logic [63:0] hi_sum;
  logic        hi_ovf;
  logic [63:0] lo_diff;
  logic        lo_ovf;

  always_comb begin
    low0              = dim.first ? dim.base : run_low;
    high0             = dim.first ? dim.base : run_high;
    start_offset_next = dim.first ? dim.base : start_offset;
    cnt0              = dim.first ? 64'd1 : elem_count;
    if (dim.first) begin
      fl0         = '0;
      fl0.neg_off = dim.base[63];
    end else begin
      fl0 = error_flags;
    end

    c_big   = (cnt0[63:32] != 32'd0);
    e_big   = (dim.ext[63:32] != 32'd0);
    s       = c_big ? dim.ext[31:0] : cnt0[31:0];
    l       = c_big ? cnt0 : dim.ext;
    q0      = 64'(s) * 64'(l[31:0]);
    q1      = 64'(s) * 64'(l[63:32]);
    prod    = {q1, 32'd0} + {32'd0, q0};
    cnt_ovf = (c_big && e_big) || (prod[95:63] != 33'd0);

    hi_sum  = high0 + dim.p;
    hi_ovf  = !high0[63] && hi_sum[63];
    lo_diff = low0 - dim.p;
    lo_ovf  = (low0[63] == dim.pnz) && (lo_diff[63] != low0[63]);

    run_low_next     = low0;
    run_high_next    = high0;
    elem_count_next  = cnt0;
    error_flags_next = fl0;
    if (!dim.scalar) begin
      if (dim.ext[63]) begin
        error_flags_next.neg_ext = 1'b1;
      end else if (dim.ext == 64'd0) begin
        error_flags_next.zero = 1'b1;
      end else begin
        if (!fl0.cnt) begin
          if (cnt_ovf) begin
            error_flags_next.cnt = 1'b1;
          end else begin
            elem_count_next = prod[63:0];
          end
        end
        if (dim.bnd_mul) begin
          error_flags_next.bnd = 1'b1;
        end else if (dim.neg) begin
          run_low_next = lo_diff;
          if (lo_ovf) begin
            error_flags_next.bnd = 1'b1;
          end
        end else begin
          run_high_next = hi_sum;
          if (hi_ovf) begin
            error_flags_next.bnd = 1'b1;
          end
        end
      end
    end

    res = '0;
    if (error_flags_next.neg_ext) begin
      res.status = ST_NEG_EXT;
    end else if (error_flags_next.neg_off) begin
      res.status = ST_NEG_OFF;
    end else if (error_flags_next.zero) begin
      res.empty   = 1'b1;
      res.lowest  = start_offset_next;
      res.highest = start_offset_next;
    end else if (error_flags_next.cnt) begin
      res.status = ST_CNT;
    end else if (error_flags_next.bnd) begin
      res.status = ST_BND;
    end else begin
      res.lowest  = run_low_next;
      res.highest = run_high_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      run_low      <= run_low_next;
      run_high     <= run_high_next;
      start_offset <= start_offset_next;
      elem_count   <= elem_count_next;
      error_flags  <= error_flags_next;
    end
  end

endmodule

[hdl/strided_tensor_bounds_check.sv]
// Top level of the strided tensor bounds checker: input register, pipeline control, result register.
//
//   channel  valid      stall      payload
//   dim      dim_valid  dim_stall  extent, stride, base_offset, scalar, last
//   res      res_valid  res_stall  status, empty_res, lowest, highest
//
// One dimension word is taken per cycle while dim_stall is low. A closing word's result passes
// through the input register, two span-product stages, then the accumulator into the
// result register. The count multiply sits in the accumulator's feedback loop.
// Reset is synchronous and empties all stages; the next word opens a new descriptor.
// A stalled result only halts the pipe when a closing word reaches the accumulator.
`include "strided_tensor_bounds_check_macros.svh"

module strided_tensor_bounds_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        dim_valid,
  output logic        dim_stall,
  input  logic [63:0] extent,
  input  logic [63:0] stride,
  input  logic [63:0] base_offset,
  input  logic        scalar,
  input  logic        last,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  status,
  output logic        empty_res,
  output logic [63:0] lowest,
  output logic [63:0] highest
);
  import stbc_pkg::*;

  item_t     item;
  dim_t      dim;
  result_t   res;
  pipe_ctl_t ctl;
  logic      first_pending;
  logic      v1;
  logic      v2;
  logic      v3;
  logic      res_free;
  logic      closes3;
  logic      adv1;
  logic      adv2;
  logic      adv3;
  logic      take_in;

  always_comb begin
    res_free   = !res_valid || !res_stall;
    closes3    = dim.scalar || dim.last;
    adv3       = v3 && (!closes3 || res_free);
    adv2       = v2 && (!v3 || adv3);
    adv1       = v1 && (!v2 || adv2);
    dim_stall  = v1 && !adv1;
    take_in    = dim_valid && !dim_stall;
    ctl.load_a = adv1;
    ctl.load_b = adv2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      first_pending <= 1'b1;
    end else begin
      v1 <= take_in || (v1 && !adv1);
      v2 <= adv1 || (v2 && !adv2);
      v3 <= adv2 || (v3 && !adv3);
      if (take_in) begin
        first_pending <= scalar || last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      item.ext    <= extent;
      item.str    <= stride;
      item.base   <= base_offset;
      item.scalar <= scalar;
      item.last   <= last;
      item.first  <= first_pending;
    end
  end

  stbc_span u_span (
    .clk  (clk),
    .ctl  (ctl),
    .item (item),
    .dim  (dim)
  );

  stbc_accum u_accum (
    .clk  (clk),
    .take (adv3),
    .dim  (dim),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv3 && closes3) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && closes3) begin
      status    <= res.status;
      empty_res <= res.empty;
      lowest    <= res.lowest;
      highest   <= res.highest;
    end
  end

  `STBC_ASSERT_NOW(a_err_clean, clk, rst, res_valid && (status != ST_OK), !empty_res && (lowest == 64'd0) && (highest == 64'd0), "Error result carries nonzero range.")
  `STBC_ASSERT_NOW(a_empty_point, clk, rst, res_valid && empty_res, (status == ST_OK) && (lowest == highest), "Empty result is not a single point.")
  `STBC_ASSERT_NOW(a_ok_order, clk, rst, res_valid && (status == ST_OK), $signed(lowest) <= $signed(highest), "Lowest offset above highest offset.")
  `STBC_ASSERT_NEXT(a_hold_acc, clk, rst, v3 && !adv3, v3, "Word lost at the accumulator stage.")

endmodule

[dv/testbench.sv]
// Self-checking testbench for the strided tensor bounds checker with its own descriptor predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import stbc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_GAP = 16;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned HOLD_SPACING = 400;
  localparam int unsigned TAIL_CYCLES = 24;
  localparam logic [63:0] POS_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

  typedef struct {
    logic [63:0] ext;
    logic [63:0] str;
    logic [63:0] base;
    logic        scal;
    logic        lst;
    int unsigned gap;
    bit          drain;
  } dim_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        dim_valid = 1'b0;
  logic        dim_stall;
  logic [63:0] extent = '0;
  logic [63:0] stride = '0;
  logic [63:0] base_offset = '0;
  logic        scalar = 1'b0;
  logic        last = 1'b0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [2:0]  status;
  logic        empty_res;
  logic [63:0] lowest;
  logic [63:0] highest;

  dim_word_t   dim_words[$];
  result_t     bounds_due[$];
  bit          dim_fire = 1'b0;
  bit          res_fire = 1'b0;
  bit          drain_next = 1'b0;
  int unsigned n_queued = 0;
  int unsigned n_words = 0;
  int unsigned n_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_gap_max = MAX_GAP;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_mark = HOLD_SPACING;

  bit          open_pending = 1'b1;
  logic [63:0] low_acc = '0;
  logic [63:0] high_acc = '0;
  logic [63:0] desc_base = '0;
  logic [63:0] elem_total = 64'd1;
  flags_t      desc_flags = '0;

  strided_tensor_bounds_check u_top (
    .clk(clk),
    .rst(rst),
    .dim_valid(dim_valid),
    .dim_stall(dim_stall),
    .extent(extent),
    .stride(stride),
    .base_offset(base_offset),
    .scalar(scalar),
    .last(last),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .status(status),
    .empty_res(empty_res),
    .lowest(lowest),
    .highest(highest)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void take_dim(logic [63:0] ext, logic [63:0] str);
    logic [63:0]  span;
    logic [63:0]  mag;
    logic [63:0]  prod;
    logic [63:0]  delta;
    logic [63:0]  acc;
    logic [63:0]  sum;
    logic [127:0] wide;
    if (ext[63]) begin
      desc_flags.neg_ext = 1'b1;
      return;
    end
    if (ext == '0) begin
      desc_flags.zero = 1'b1;
      return;
    end
    if (!desc_flags.cnt) begin
      if (elem_total > POS_MAX / ext) desc_flags.cnt = 1'b1;
      else elem_total = elem_total * ext;
    end
    span = ext - 64'd1;
    mag = str[63] ? -str : str;
    wide = {64'd0, span} * {64'd0, mag};
    prod = wide[63:0];
    if (wide[127:64] != '0 || prod > (str[63] ? NEG_MIN : POS_MAX)) begin
      desc_flags.bnd = 1'b1;
      return;
    end
    delta = str[63] ? -prod : prod;
    acc = str[63] ? low_acc : high_acc;
    sum = acc + delta;
    if (acc[63] == delta[63] && sum[63] != acc[63]) desc_flags.bnd = 1'b1;
    if (str[63]) low_acc = sum;
    else high_acc = sum;
  endfunction

  function automatic void predict_word(input dim_word_t w, output bit closes,
                                       output result_t r);
    r = '0;
    closes = 1'b0;
    if (open_pending) begin
      desc_base = w.base;
      low_acc = w.base;
      high_acc = w.base;
      elem_total = 64'd1;
      desc_flags = '0;
      desc_flags.neg_off = w.base[63];
      open_pending = 1'b0;
    end
    if (!w.scal) take_dim(w.ext, w.str);
    if (w.scal || w.lst) begin
      closes = 1'b1;
      open_pending = 1'b1;
      if (desc_flags.neg_ext) begin
        r.status = ST_NEG_EXT;
      end else if (desc_flags.neg_off) begin
        r.status = ST_NEG_OFF;
      end else if (desc_flags.zero) begin
        r.status = ST_OK;
        r.empty = 1'b1;
        r.lowest = desc_base;
        r.highest = desc_base;
      end else if (desc_flags.cnt) begin
        r.status = ST_CNT;
      end else if (desc_flags.bnd) begin
        r.status = ST_BND;
      end else begin
        r.status = ST_OK;
        r.lowest = low_acc;
        r.highest = high_acc;
      end
    end
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_extent();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return rand64() | NEG_MIN;
      2: return rand64();
      3: return 64'd1 << $urandom_range(0, 62);
      4: return 64'd1 + $urandom_range(0, 65535);
      default: return 64'd0 + $urandom_range(1, 8);
    endcase
  endfunction

  function automatic logic [63:0] pick_stride();
    case ($urandom_range(0, 11))
      0: return rand64();
      1: return NEG_MIN;
      2: return POS_MAX;
      3: return 64'd1 << $urandom_range(0, 62);
      4: return -(64'd1 << $urandom_range(0, 62));
      5: return 64'd0 + $urandom_range(0, 100000);
      default: return $urandom_range(0, 32) - 64'd16;
    endcase
  endfunction

  function automatic logic [63:0] pick_base();
    case ($urandom_range(0, 9))
      0: return rand64() | NEG_MIN;
      1: return rand64();
      2: return POS_MAX - $urandom_range(0, 64);
      3: return '0;
      4: return rand64() & POS_MAX;
      default: return 64'd0 + $urandom_range(0, 4096);
    endcase
  endfunction

  task automatic queue_word(logic [63:0] ext, logic [63:0] str, logic [63:0] base,
                            logic scal, logic lst);
    dim_word_t w;
    w.ext = ext;
    w.str = str;
    w.base = base;
    w.scal = scal;
    w.lst = lst;
    w.gap = $urandom_range(0, send_gap_max);
    w.drain = drain_next;
    drain_next = 1'b0;
    dim_words.push_back(w);
    n_queued++;
  endtask

  task automatic queue_descriptor();
    int unsigned rank;
    logic [63:0] base;
    logic        scal;
    logic        lst;
    rank = $urandom_range(0, 6);
    base = pick_base();
    if ($urandom_range(0, 9) == 0) begin
      queue_word(rand64(), rand64(), rand64(), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    end else if (rank == 0) begin
      queue_word(rand64(), rand64(), base, 1'b1, 1'($urandom_range(0, 1)));
    end else begin
      for (int unsigned i = 1; i <= rank; i++) begin
        scal = 1'b0;
        lst = (i == rank);
        if (lst && $urandom_range(0, 9) == 0) begin
          scal = 1'b1;
          lst = 1'($urandom_range(0, 1));
        end
        queue_word(pick_extent(), pick_stride(), (i == 1) ? base : rand64(), scal, lst);
      end
    end
  endtask

  initial begin
    queue_word(64'd3, 64'd4, 64'd5, 1'b1, 1'b0);
    queue_word('0, '0, NEG_MIN | 64'd7, 1'b1, 1'b0);
    queue_word('1, '1, POS_MAX, 1'b1, 1'b1);
    queue_word(64'd1, rand64(), '0, 1'b0, 1'b1);
    queue_word(64'd3, 64'd4, 64'd10, 1'b0, 1'b0);
    queue_word(64'd3, -64'd4, '0, 1'b0, 1'b1);
    queue_word('1, 64'd1, 64'd20, 1'b0, 1'b1);
    queue_word(NEG_MIN, 64'd1, 64'd20, 1'b0, 1'b0);
    queue_word(64'd5, 64'd1, '0, 1'b0, 1'b1);
    queue_word('0, 64'd7, 64'd33, 1'b0, 1'b0);
    queue_word(64'd5, 64'd1, '0, 1'b0, 1'b1);
    queue_word('0, 64'd7, NEG_MIN, 1'b0, 1'b1);
    queue_word(64'd1 << 32, '0, '0, 1'b0, 1'b0);
    queue_word(64'd1 << 32, '0, '0, 1'b0, 1'b1);
    queue_word(64'd1 << 32, '0, '0, 1'b0, 1'b0);
    queue_word(64'd1 << 32, '0, '0, 1'b0, 1'b0);
    queue_word(64'd3, 64'd1, '0, 1'b0, 1'b1);
    queue_word(64'd2, POS_MAX, 64'd1, 1'b0, 1'b1);
    queue_word(64'd2, NEG_MIN, '0, 1'b0, 1'b1);
    queue_word(POS_MAX, 64'd1, '0, 1'b0, 1'b1);
    queue_word(64'd3, 64'd1, 64'd4, 1'b0, 1'b0);
    queue_word(-64'd5, 64'd9, '0, 1'b1, 1'b0);
    queue_word(64'd2, 64'd5, '0, 1'b0, 1'b0);
    queue_word('0, '0, '0, 1'b1, 1'b1);
    queue_word(64'd3, NEG_MIN, '0, 1'b0, 1'b1);

    drain_next = 1'b1;
    while (n_queued < 330) queue_descriptor();
    send_gap_max = 0;
    drain_next = 1'b1;
    while (n_queued < 620) queue_descriptor();
    send_gap_max = MAX_GAP;
    drain_next = 1'b1;
    while (n_queued < 970) queue_descriptor();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (dim_words.size() != 0 || dim_valid) @(negedge clk);
    while (bounds_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  always @(negedge clk) begin : drive
    dim_word_t w;
    if (rst) begin
      dim_valid <= 1'b0;
    end else if (!dim_valid || dim_fire) begin
      if (dim_fire && dim_words.size() != 0) gap_left = dim_words[0].gap;
      if (gap_left != 0) begin
        gap_left--;
        dim_valid <= 1'b0;
      end else if (dim_words.size() != 0 &&
                   (!dim_words[0].drain || bounds_due.size() == 0)) begin
        w = dim_words.pop_front();
        extent <= w.ext;
        stride <= w.str;
        base_offset <= w.base;
        scalar <= w.scal;
        last <= w.lst;
        dim_valid <= 1'b1;
      end else begin
        dim_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_fire) stall_left = $urandom_range(0, ((n_checked / 50) % 3 == 1) ? 0 : MAX_GAP);
      if (hold_left == 0 && n_words >= hold_mark) begin
        hold_left = HOLD_CYCLES;
        hold_mark += HOLD_SPACING;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch
    dim_word_t w;
    result_t   want;
    result_t   got;
    bit        closes;
    dim_fire <= !rst && dim_valid && !dim_stall;
    res_fire <= !rst && res_valid && !res_stall;
    if (rst) begin
      open_pending = 1'b1;
    end else if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      cycles++;
      if (dim_valid && !dim_stall) begin
        w.ext = extent;
        w.str = stride;
        w.base = base_offset;
        w.scal = scalar;
        w.lst = last;
        n_words++;
        predict_word(w, closes, want);
        if (closes) bounds_due.push_back(want);
      end
      if (res_valid && !res_stall) begin
        got.status = status;
        got.empty = empty_res;
        got.lowest = lowest;
        got.highest = highest;
        if (bounds_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: status %0d empty %0b lowest %h highest %h",
                     got.status, got.empty, got.lowest, got.highest);
        end else begin
          want = bounds_due.pop_front();
          n_checked++;
          if (got.status !== want.status || got.empty !== want.empty ||
              got.lowest !== want.lowest || got.highest !== want.highest) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result word %0d: expected status %0d empty %0b lowest %h highest %h, %s",
                       n_checked, want.status, want.empty, want.lowest, want.highest,
                       $sformatf("got status %0d empty %0b lowest %h highest %h",
                                 got.status, got.empty, got.lowest, got.highest));
          end
        end
      end
    end
  end

endmodule
